// ----- rtl/core/bitmap_shape_rasterizer_defines.svh -----
// Assertion macros for the bitmap shape rasterizer
`ifndef BITMAP_SHAPE_RASTERIZER_DEFINES_SVH
`define BITMAP_SHAPE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define BSR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define BSR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bsr_pkg.sv -----
// Shared types, command codes and helpers of the bitmap shape rasterizer
package bsr_pkg;

  localparam int ROW_BITS = 64;

  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_RECT  = 3'd1;
  localparam logic [2:0] FUNC_LINE  = 3'd2;
  localparam logic [2:0] FUNC_TRI   = 3'd3;
  localparam logic [2:0] FUNC_CIRC  = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  typedef logic signed [10:0] coord_t;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic signed [7:0] end_x;
    logic signed [7:0] end_y;
    logic [6:0]        size_w;
    logic [6:0]        size_h;
    logic [6:0]        radius;
  } cmd_t;

  // Two inclusive column spans; lo > hi means empty
  typedef struct packed {
    coord_t lo0;
    coord_t hi0;
    coord_t lo1;
    coord_t hi1;
  } span_t;

  localparam coord_t SPAN_LO_EMPTY = 11'sd1;
  localparam coord_t SPAN_HI_EMPTY = 11'sd0;

  function automatic logic [ROW_BITS-1:0] range_mask(coord_t lo, coord_t hi);
    logic [ROW_BITS-1:0] m;
    for (int c = 0; c < ROW_BITS; c++) begin
      m[c] = (coord_t'(c) >= lo) && (coord_t'(c) <= hi);
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/bsr_if.sv -----
// Command and row-result channel interfaces
interface bsr_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic signed [7:0] pos_x;
  logic signed [7:0] pos_y;
  logic signed [7:0] end_x;
  logic signed [7:0] end_y;
  logic [6:0]        size_w;
  logic [6:0]        size_h;
  logic [6:0]        radius;

  modport source (output valid, func, pos_x, pos_y, end_x, end_y, size_w, size_h, radius,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, end_x, end_y, size_w, size_h, radius,
                output ready);
endinterface

interface bsr_row_if;
  logic        valid;
  logic        ready;
  logic [4:0]  row_index;
  logic [63:0] row_bits;

  modport source (output valid, row_index, row_bits, input ready);
  modport sink (input valid, row_index, row_bits, output ready);
endinterface

// ----- rtl/core/bitmap_shape_rasterizer.sv -----
// Bitmap shape rasterizer: 1-bpp canvas, draw sequencer and row readout
// Rectangle, line, triangle: one row read-modify-write per cycle.
// Circle: radius squared first, then per row one dy^2 step and seven isqrt
//   bisection steps on the shared 8x8 squarer, then the row write.
// Clear: handled on accept. Read row: RAM read in S_RSP, word registered in S_ROUT once the output is free.
// Reset and clear drop per-row written flags at once; no sweep, unwritten rows read as 0.
`include "bitmap_shape_rasterizer_defines.svh"

module bitmap_shape_rasterizer #(
  parameter int CANVAS_ROWS = 32,
  parameter int CANVAS_COLS = 64
) (
  input logic         clk,
  input logic         rst,
  bsr_cmd_if.sink     cmd,
  bsr_row_if.source   rsp
);

  localparam int ROW_AW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CPREP = 3'd1;
  localparam logic [2:0] S_CDY   = 3'd2;
  localparam logic [2:0] S_CBIS  = 3'd3;
  localparam logic [2:0] S_CWR   = 3'd4;
  localparam logic [2:0] S_FWR   = 3'd5;
  localparam logic [2:0] S_RSP   = 3'd6;
  localparam logic [2:0] S_ROUT  = 3'd7;

  logic [2:0]              state;
  logic [ROW_AW-1:0]       row;
  bsr_pkg::cmd_t           cmd_q;
  logic [13:0]             radsq;
  logic signed [16:0]      tval;
  logic [6:0]              k;
  logic [2:0]              bitn;
  logic [CANVAS_ROWS-1:0]  valid;
  logic                    out_valid;
  logic [4:0]              out_index;
  logic [63:0]             out_bits;

  bsr_pkg::cmd_t           cmd_in;
  bsr_pkg::coord_t         r_c;
  bsr_pkg::coord_t         dy;
  logic [7:0]              dy_abs;
  logic [6:0]              cand;
  logic [7:0]              sq_op;
  logic [15:0]             sq;
  logic                    last_row;
  logic                    read_ok;
  logic                    out_free;
  logic [ROW_AW-1:0]       raddr;
  logic                    we;
  logic [CANVAS_COLS-1:0]  rdata;
  logic [CANVAS_COLS-1:0]  row_data;
  logic [CANVAS_COLS-1:0]  wdata;
  logic [bsr_pkg::ROW_BITS-1:0] mask;
  logic [6:0]              row_ext;
  bsr_pkg::span_t          span;

  assign cmd_in.func   = cmd.func;
  assign cmd_in.pos_x  = cmd.pos_x;
  assign cmd_in.pos_y  = cmd.pos_y;
  assign cmd_in.end_x  = cmd.end_x;
  assign cmd_in.end_y  = cmd.end_y;
  assign cmd_in.size_w = cmd.size_w;
  assign cmd_in.size_h = cmd.size_h;
  assign cmd_in.radius = cmd.radius;

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.row_index = out_index;
  assign rsp.row_bits  = out_bits;

  assign r_c      = bsr_pkg::coord_t'(row);
  assign dy       = r_c - bsr_pkg::coord_t'($signed(cmd_q.pos_y));
  assign dy_abs   = dy[10] ? 8'(-dy) : 8'(dy);
  assign cand     = k | (7'd1 << bitn);
  assign last_row = (row == ROW_AW'(CANVAS_ROWS - 1));
  assign read_ok  = !cmd.pos_y[7] && (cmd.pos_y[6:0] < 7'(CANVAS_ROWS));
  assign out_free = !out_valid || rsp.ready;
  assign row_ext  = 7'(row);

  // shared squarer
  always_comb begin
    case (state)
      S_CPREP: sq_op = {1'b0, cmd_q.radius};
      S_CDY:   sq_op = dy_abs;
      S_CBIS:  sq_op = {1'b0, cand};
      default: sq_op = '0;
    endcase
  end
  assign sq = sq_op * sq_op;

  always_comb begin
    case (state) inside
      S_FWR:                          raddr = last_row ? '0 : row + ROW_AW'(1);
      S_CDY, S_CBIS, S_CWR, S_RSP, S_ROUT: raddr = row;
      default:                        raddr = '0;
    endcase
  end

  assign we       = (state == S_FWR) || (state == S_CWR);
  assign row_data = valid[row] ? rdata : '0;
  assign mask     = bsr_pkg::range_mask(span.lo0, span.hi0)
                  | bsr_pkg::range_mask(span.lo1, span.hi1);
  assign wdata    = row_data | mask[CANVAS_COLS-1:0];

  bsr_span u_span (
    .cmd     (cmd_q),
    .r       (r_c),
    .circ_k  (k),
    .circ_on (!tval[16]),
    .span    (span)
  );

  bsr_ram #(
    .WIDTH (CANVAS_COLS),
    .DEPTH (CANVAS_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (row),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_ROUT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (we) begin
        valid[row] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_q <= cmd_in;
            row   <= '0;
            unique case (cmd.func) inside
              bsr_pkg::FUNC_CLEAR: valid <= '0;
              bsr_pkg::FUNC_RECT, bsr_pkg::FUNC_LINE, bsr_pkg::FUNC_TRI: state <= S_FWR;
              bsr_pkg::FUNC_CIRC: state <= S_CPREP;
              bsr_pkg::FUNC_READ: begin
                if (read_ok) begin
                  row   <= ROW_AW'(cmd.pos_y[6:0]);
                  state <= S_RSP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CPREP: begin
          radsq <= sq[13:0];
          state <= S_CDY;
        end
        S_CDY: begin
          tval  <= $signed({3'b000, radsq}) - $signed({1'b0, sq});
          k     <= '0;
          bitn  <= 3'd6;
          state <= S_CBIS;
        end
        S_CBIS: begin
          if (!tval[16] && $signed({1'b0, sq}) <= tval) begin
            k <= cand;
          end
          if (bitn == 3'd0) begin
            state <= S_CWR;
          end else begin
            bitn <= bitn - 3'd1;
          end
        end
        S_CWR: begin
          if (last_row) begin
            state <= S_IDLE;
          end else begin
            row   <= row + ROW_AW'(1);
            state <= S_CDY;
          end
        end
        S_FWR: begin
          if (last_row) begin
            state <= S_IDLE;
          end else begin
            row <= row + ROW_AW'(1);
          end
        end
        S_RSP: state <= S_ROUT;
        S_ROUT: begin
          if (out_free) begin
            out_index <= row_ext[4:0];
            out_bits  <= 64'(row_data);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BSR_ASSERT_NXT(a_clear_empties,
    cmd.valid && cmd.ready && cmd.func == bsr_pkg::FUNC_CLEAR, valid == '0,
    "clear left a row marked written")
  `BSR_ASSERT_IMP(a_word_from_read, $rose(rsp.valid), $past(state) == S_ROUT,
    "result word without a read")
  `BSR_ASSERT_IMP(a_circ_k_bound, state == S_CWR && !tval[16], k <= cmd_q.radius,
    "circle half-width beyond radius")

endmodule

// ----- rtl/core/bsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module bsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bsr_span.sv -----
// Per-row column spans of the shape being drawn
module bsr_span (
  input  bsr_pkg::cmd_t   cmd,
  input  bsr_pkg::coord_t r,
  input  logic [6:0]      circ_k,
  input  logic            circ_on,
  output bsr_pkg::span_t  span
);

  bsr_pkg::coord_t px, py, ex, ey, w, h, k, xr, yb, a;

  always_comb begin
    px = bsr_pkg::coord_t'($signed(cmd.pos_x));
    py = bsr_pkg::coord_t'($signed(cmd.pos_y));
    ex = bsr_pkg::coord_t'($signed(cmd.end_x));
    ey = bsr_pkg::coord_t'($signed(cmd.end_y));
    w  = bsr_pkg::coord_t'(cmd.size_w);
    h  = bsr_pkg::coord_t'(cmd.size_h);
    k  = bsr_pkg::coord_t'(circ_k);
    xr = px + w - 11'sd1;
    yb = py + h - 11'sd1;
    a  = r - py;

    span.lo0 = bsr_pkg::SPAN_LO_EMPTY;
    span.hi0 = bsr_pkg::SPAN_HI_EMPTY;
    span.lo1 = bsr_pkg::SPAN_LO_EMPTY;
    span.hi1 = bsr_pkg::SPAN_HI_EMPTY;

    unique case (cmd.func)
      bsr_pkg::FUNC_RECT: begin
        if (cmd.size_w != '0 && cmd.size_h != '0 && r >= py && r <= yb) begin
          if (r == py || r == yb) begin
            span.lo0 = px;
            span.hi0 = xr;
          end else begin
            span.lo0 = px;
            span.hi0 = px;
            span.lo1 = xr;
            span.hi1 = xr;
          end
        end
      end
      bsr_pkg::FUNC_LINE: begin
        if (ey == py) begin
          if (r == py) begin
            span.lo0 = px;
            span.hi0 = ex;
          end
        end else if (ex == px) begin
          if (r >= py && r <= ey) begin
            span.lo0 = px;
            span.hi0 = px;
          end
        end
      end
      bsr_pkg::FUNC_TRI: begin
        if (a >= 11'sd0 && a < h) begin
          span.lo0 = px;
          span.hi0 = px + a;
        end
      end
      bsr_pkg::FUNC_CIRC: begin
        if (circ_on) begin
          span.lo0 = px - k;
          span.hi0 = px + k;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- tb/bitmap_shape_rasterizer_test.sv -----
// Self-checking testbench for the bitmap shape rasterizer: draws, clears and row reads
`timescale 1ns / 100ps

module bitmap_shape_rasterizer_test;

  localparam int ROWS = 32;
  localparam int COLS = 64;
  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 400;

  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  typedef struct {
    logic [4:0]  index;
    logic [63:0] bits;
  } row_word_t;

  logic clk;
  logic rst;

  bsr_cmd_if cmd_ch ();
  bsr_row_if row_ch ();

  bitmap_shape_rasterizer u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (row_ch)
  );

  bsr_pkg::cmd_t pending_cmds[$];
  row_word_t     expected_rows[$];
  logic [63:0]   canvas_model[ROWS];

  bsr_pkg::cmd_t cur_cmd;
  row_word_t want;
  int        fail_count = 0;
  int        draws_sent = 0;
  int        clears_sent = 0;
  int        reads_sent = 0;
  int        ignored_sent = 0;
  int        rows_checked = 0;
  int        idle_cycles = 0;

  // Predictor
  function automatic bit pixel_covered(bsr_pkg::cmd_t c, int r, int col);
    int px, py, ex, ey, w, h, rad, a, b, dx, dy;
    px  = $signed(c.pos_x);
    py  = $signed(c.pos_y);
    ex  = $signed(c.end_x);
    ey  = $signed(c.end_y);
    w   = c.size_w;
    h   = c.size_h;
    rad = c.radius;
    case (c.func)
      bsr_pkg::FUNC_RECT: begin
        if (r < py || r >= py + h || col < px || col >= px + w) return 1'b0;
        return r == py || r == py + h - 1 || col == px || col == px + w - 1;
      end
      bsr_pkg::FUNC_LINE: begin
        if (py == ey) return r == py && col >= px && col <= ex;
        if (px == ex) return col == px && r >= py && r <= ey;
        return 1'b0;
      end
      bsr_pkg::FUNC_TRI: begin
        a = r - py;
        b = col - px;
        return a >= 0 && a < h && b >= 0 && b <= a;
      end
      bsr_pkg::FUNC_CIRC: begin
        dx = col - px;
        dy = r - py;
        return dx * dx + dy * dy <= rad * rad;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void paint_cmd(bsr_pkg::cmd_t c);
    int py;
    row_word_t w;
    py = $signed(c.pos_y);
    case (c.func) inside
      bsr_pkg::FUNC_CLEAR: begin
        for (int r = 0; r < ROWS; r++) canvas_model[r] = '0;
      end
      bsr_pkg::FUNC_READ: begin
        if (py >= 0 && py < ROWS) begin
          w.index = py[4:0];
          w.bits  = canvas_model[py];
          expected_rows.push_back(w);
        end
      end
      bsr_pkg::FUNC_RECT, bsr_pkg::FUNC_LINE, bsr_pkg::FUNC_TRI, bsr_pkg::FUNC_CIRC: begin
        for (int r = 0; r < ROWS; r++)
          for (int col = 0; col < COLS; col++)
            if (pixel_covered(c, r, col)) canvas_model[r][col] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Stimulus helpers
  function automatic bsr_pkg::cmd_t random_cmd();
    bsr_pkg::cmd_t c;
    c.func   = 3'($urandom);
    c.pos_x  = 8'($urandom);
    c.pos_y  = 8'($urandom);
    c.end_x  = 8'($urandom);
    c.end_y  = 8'($urandom);
    c.size_w = 7'($urandom);
    c.size_h = 7'($urandom);
    c.radius = 7'($urandom);
    return c;
  endfunction

  function automatic void push_cmd(logic [2:0] f, int px, int py, int ex, int ey,
                                   int w, int h, int rad);
    bsr_pkg::cmd_t c;
    c = random_cmd();
    c.func   = f;
    c.pos_x  = px[7:0];
    c.pos_y  = py[7:0];
    c.end_x  = ex[7:0];
    c.end_y  = ey[7:0];
    c.size_w = w[6:0];
    c.size_h = h[6:0];
    c.radius = rad[6:0];
    pending_cmds.push_back(c);
  endfunction

  function automatic int pick_coord(int lo, int hi);
    if ($urandom_range(0, 99) < 15) return int'($urandom_range(0, 255)) - 128;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_size(int near_max);
    if ($urandom_range(0, 99) < 12) return $urandom_range(0, 127);
    return $urandom_range(0, near_max);
  endfunction

  function automatic void build_random_cmds();
    int   counted, sel, kind;
    bsr_pkg::cmd_t c;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      c   = random_cmd();
      sel = $urandom_range(0, 99);
      counted++;
      if (sel < 4) begin
        c.func = bsr_pkg::FUNC_CLEAR;
      end else if (sel < 18) begin
        c.func   = bsr_pkg::FUNC_RECT;
        c.pos_x  = 8'(pick_coord(-10, 70));
        c.pos_y  = 8'(pick_coord(-10, 38));
        c.size_w = 7'(pick_size(40));
        c.size_h = 7'(pick_size(20));
      end else if (sel < 36) begin
        c.func  = bsr_pkg::FUNC_LINE;
        c.pos_x = 8'(pick_coord(-10, 70));
        c.pos_y = 8'(pick_coord(-10, 38));
        kind = $urandom_range(0, 4);
        case (kind)
          0: begin
            c.end_y = c.pos_y;
            c.end_x = c.pos_x + 8'($urandom_range(0, 40));
          end
          1: begin
            c.end_x = c.pos_x;
            c.end_y = c.pos_y + 8'($urandom_range(0, 25));
          end
          2: begin
            c.end_y = c.pos_y;
            c.end_x = c.pos_x - 8'($urandom_range(1, 20));
          end
          3: begin
            c.end_x = c.pos_x;
            c.end_y = c.pos_y - 8'($urandom_range(1, 20));
          end
          default: ;
        endcase
      end else if (sel < 48) begin
        c.func   = bsr_pkg::FUNC_TRI;
        c.pos_x  = 8'(pick_coord(-15, 66));
        c.pos_y  = 8'(pick_coord(-15, 34));
        c.size_h = 7'(pick_size(20));
      end else if (sel < 58) begin
        c.func   = bsr_pkg::FUNC_CIRC;
        c.pos_x  = 8'(pick_coord(-8, 71));
        c.pos_y  = 8'(pick_coord(-8, 39));
        c.radius = 7'(pick_size(10));
      end else if (sel < 96) begin
        c.func  = bsr_pkg::FUNC_READ;
        c.pos_y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, ROWS - 1));
      end else begin
        c.func = $urandom_range(0, 1) ? FUNC_RSVD6 : FUNC_RSVD7;
      end
      pending_cmds.push_back(c);
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Command driver: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        paint_cmd(cur_cmd);
        case (cur_cmd.func) inside
          bsr_pkg::FUNC_CLEAR: clears_sent++;
          bsr_pkg::FUNC_READ:  reads_sent++;
          bsr_pkg::FUNC_RECT, bsr_pkg::FUNC_LINE, bsr_pkg::FUNC_TRI, bsr_pkg::FUNC_CIRC:
            draws_sent++;
          default:    ignored_sent++;
        endcase
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_ch.valid  <= 1'b1;
          cmd_ch.func   <= cur_cmd.func;
          cmd_ch.pos_x  <= cur_cmd.pos_x;
          cmd_ch.pos_y  <= cur_cmd.pos_y;
          cmd_ch.end_x  <= cur_cmd.end_x;
          cmd_ch.end_y  <= cur_cmd.end_y;
          cmd_ch.size_w <= cur_cmd.size_w;
          cmd_ch.size_h <= cur_cmd.size_h;
          cmd_ch.radius <= cur_cmd.radius;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Row receiver: stall pattern per window, plus two long hold-offs
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_words = 0;
  int holds_taken = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      row_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (row_ch.valid && row_ch.ready) rx_words++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      if ((holds_taken == 0 && rx_words >= 20) || (holds_taken == 1 && rx_words >= 120)) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        row_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       row_ch.ready <= 1'b1;
          1:       row_ch.ready <= (rx_cycle % 5) > 1;
          default: row_ch.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Row word checker
  always @(posedge clk) begin
    if (!rst && row_ch.valid && row_ch.ready) begin
      if (expected_rows.size() == 0) begin
        $error("row word with nothing expected: row_index %0d row_bits %h",
               row_ch.row_index, row_ch.row_bits);
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (row_ch.row_index !== want.index) begin
          $error("row_index: expected %0d, got %0d", want.index, row_ch.row_index);
          fail_count++;
        end
        if (row_ch.row_bits !== want.bits) begin
          $error("row_bits: expected %h, got %h", want.bits, row_ch.row_bits);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (row_ch.valid && row_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL bitmap_shape_rasterizer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    for (int r = 0; r < ROWS; r++) canvas_model[r] = '0;

    push_cmd(bsr_pkg::FUNC_READ,   0,    0,    0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_RECT,   0,    0,    0,    0,    64,  32,  0);
    push_cmd(bsr_pkg::FUNC_READ,   0,    31,   0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_CLEAR,  0,    0,    0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_RECT,   -5,   -3,   0,    0,    10,  8,   0);
    push_cmd(bsr_pkg::FUNC_RECT,   60,   28,   0,    0,    127, 127, 0);
    push_cmd(bsr_pkg::FUNC_RECT,   10,   10,   0,    0,    0,   5,   0);
    push_cmd(bsr_pkg::FUNC_RECT,   10,   10,   0,    0,    5,   0,   0);
    push_cmd(bsr_pkg::FUNC_LINE,   -10,  5,    127,  5,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_LINE,   63,   -128, 63,   127,  0,   0,   0);
    push_cmd(bsr_pkg::FUNC_LINE,   1,    1,    10,   10,   0,   0,   0);
    push_cmd(bsr_pkg::FUNC_LINE,   20,   7,    10,   7,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_LINE,   40,   9,    40,   9,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_TRI,    3,    3,    0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_TRI,    -20,  -10,  0,    0,    0,   127, 0);
    push_cmd(bsr_pkg::FUNC_CIRC,   10,   20,   0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_CIRC,   -128, -128, 0,    0,    0,   0,   127);
    push_cmd(bsr_pkg::FUNC_CIRC,   30,   15,   0,    0,    0,   0,   6);
    push_cmd(FUNC_RSVD6,           1,    1,    1,    1,    1,   1,   1);
    push_cmd(FUNC_RSVD7,           2,    2,    2,    2,    2,   2,   2);
    push_cmd(bsr_pkg::FUNC_READ,   0,    -1,   0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_READ,   0,    32,   0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_READ,   0,    5,    0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_READ,   0,    20,   0,    0,    0,   0,   0);
    push_cmd(bsr_pkg::FUNC_READ,   0,    0,    0,    0,    0,   0,   0);
    build_random_cmds();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_rows.size() != 0) begin
      $error("%0d row words never arrived", expected_rows.size());
      fail_count++;
    end
    $display("covered %0d draws, %0d clears, %0d reads, %0d ignored commands",
             draws_sent, clears_sent, reads_sent, ignored_sent);
    $display("%0d row words checked, %0d receiver hold-offs", rows_checked, holds_taken);
    if (fail_count == 0) begin
      $display("PASS bitmap_shape_rasterizer");
    end else begin
      $display("FAIL bitmap_shape_rasterizer");
    end
    $finish;
  end

endmodule
